// ===== sv/isf32_pkg.sv =====
package isf32_pkg;

    // identifier length in bytes, carried in the top byte of the final block
    localparam int ID_BYTES = 32;
    localparam int WORD_W   = 64;
    localparam int ID_WORDS = ID_BYTES / 8;

    // block rounds, finish rounds and resulting pipeline depth
    localparam int C_ROUNDS   = 2;
    localparam int D_ROUNDS   = 4;
    localparam int BLOCKS     = ID_WORDS + 1;
    localparam int FIN_STAGE  = BLOCKS * C_ROUNDS;
    localparam int NUM_STAGES = FIN_STAGE + D_ROUNDS;

    localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3 = 64'h7465646279746573;

    localparam logic [63:0] LEN_WORD = {8'(ID_BYTES), 56'h0};
    localparam logic [63:0] FIN_MARK = 64'h00000000000000ff;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 8'd1;

    typedef struct packed {
        logic [63:0] d;
        logic [63:0] c;
        logic [63:0] b;
        logic [63:0] a;
    } lanes_t;

    // identifier words, word 0 in the lowest bits
    typedef logic [ID_WORDS-1:0][WORD_W-1:0] msg_t;

    // one sipround
    function automatic lanes_t sip_round(lanes_t s);
        lanes_t r;
        r = s;
        r.a = r.a + r.b;
        r.b = {r.b[50:0], r.b[63:51]};
        r.b = r.b ^ r.a;
        r.a = {r.a[31:0], r.a[63:32]};
        r.c = r.c + r.d;
        r.d = {r.d[47:0], r.d[63:48]};
        r.d = r.d ^ r.c;
        r.a = r.a + r.d;
        r.d = {r.d[42:0], r.d[63:43]};
        r.d = r.d ^ r.a;
        r.c = r.c + r.b;
        r.b = {r.b[46:0], r.b[63:47]};
        r.b = r.b ^ r.c;
        r.c = {r.c[31:0], r.c[63:32]};
        return r;
    endfunction

    // xor of the four lanes folded to 32 bits
    function automatic logic [31:0] fold_digest(lanes_t s);
        logic [63:0] h;
        h = s.a ^ s.b ^ s.c ^ s.d;
        return h[31:0] ^ h[63:32];
    endfunction

endpackage

// ===== sv/id_siphash_fold32.sv =====
// SipHash-2-4 over one 32-byte identifier per beat, digest folded to 32 bits
// (high half xored into low half), keyed by two 64-bit registers written on
// the cfg channel (index 0 key_low, index 1 key_high, other indexes ignored).
// One identifier is accepted every cycle unless back-pressure fills the
// pipeline; 14 pipeline stages each run one sipround (ten for the five
// blocks, four for the finish) and one output register holds the folded
// hash. Each stage has its own valid bit and holds under back-pressure, so
// empty stages fill while the output stalls. Keys must only change while the
// pipeline is empty. cfg_ready is always high.
module id_siphash_fold32
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [isf32_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [63:0]                          cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // id_word0 [63:0], id_word1 [127:64], id_word2 [191:128], id_word3 [255:192]
    input  logic [255:0]                         s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // id_hash [31:0]
    output logic [31:0]                          m_axis_tdata
);
    import isf32_pkg::*;

    localparam int LAST = NUM_STAGES - 1;

    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;

    lanes_t lane_reg [NUM_STAGES];
    msg_t   msg_reg  [NUM_STAGES];
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] stage_ready;

    lanes_t lane_in   [NUM_STAGES];
    msg_t   msg_in    [NUM_STAGES];
    lanes_t lane_next [NUM_STAGES];

    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_ready;

    // key registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // stage inputs: key-derived lanes for the first stage
    always_comb
    begin
        lane_in[0].a = key_low_reg ^ SIP_C0;
        lane_in[0].b = key_high_reg ^ SIP_C1;
        lane_in[0].c = key_low_reg ^ SIP_C2;
        lane_in[0].d = key_high_reg ^ SIP_C3;
        msg_in[0]    = s_axis_tdata;
        valid_next[0] = s_axis_tvalid;
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            lane_in[k]    = lane_reg[k-1];
            msg_in[k]     = msg_reg[k-1];
            valid_next[k] = valid_reg[k-1];
        end
    end

    // per-stage ready chain from the output back
    assign out_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        stage_ready[LAST] = !valid_reg[LAST] || out_ready;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    assign s_axis_tready = stage_ready[0];

    // one sipround per stage with block absorb and finish marks
    for (genvar k = 0; k < NUM_STAGES; k++)
    begin : g_stage
        localparam int BLK = k / C_ROUNDS;
        localparam int PHASE = k % C_ROUNDS;
        localparam logic [1:0] WSEL = 2'(BLK % ID_WORDS);

        logic [63:0] word;
        lanes_t      pre;
        lanes_t      rnd;

        always_comb
        begin
            word = (BLK < ID_WORDS) ? msg_in[k][WSEL] : LEN_WORD;
            pre  = lane_in[k];
            if (k < FIN_STAGE && PHASE == 0)
            begin
                pre.d = pre.d ^ word;
            end
            if (k == FIN_STAGE)
            begin
                pre.c = pre.c ^ FIN_MARK;
            end
            rnd = sip_round(pre);
            if (k < FIN_STAGE && PHASE == C_ROUNDS - 1)
            begin
                rnd.a = rnd.a ^ word;
            end
            lane_next[k] = rnd;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (stage_ready[k])
            begin
                valid_reg[k] <= valid_next[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_ready[k])
            begin
                lane_reg[k] <= lane_next[k];
                msg_reg[k]  <= msg_in[k];
            end
        end
    end

    // output register with the folded digest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= valid_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            out_data_reg <= fold_digest(lane_reg[LAST]);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // accepted beat lands in the first stage
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> valid_reg[0])
        else $error("accepted beat missing from first stage");

    // last stage holds while the output is stalled
    a_last_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[LAST] && out_valid_reg && !m_axis_tready)
        |=> (valid_reg[LAST] && $stable(lane_reg[LAST])))
        else $error("last stage changed under stall");

    // first stage holds its identifier when blocked
    a_first_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[0] && !stage_ready[0]) |=> (valid_reg[0] && $stable(msg_reg[0])))
        else $error("first stage changed under stall");

endmodule
